// ===== hdl/sle_pkg.sv =====
// Shared constants, codes and controller/datapath interface types for the list engine.
`timescale 1ns / 1ps
package sle_pkg;

    localparam int MAX_ENTRIES = 64;
    localparam int ELEM_BITS   = 32;
    localparam int ADDR_W      = $clog2(MAX_ENTRIES);
    localparam int LEN_W       = $clog2(MAX_ENTRIES + 1);
    localparam int CMD_W       = 3;
    localparam int POS_W       = 7;
    localparam int ST_W        = 2;

    localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_INSERT = 3'd1;
    localparam logic [CMD_W-1:0] CMD_DELETE = 3'd2;
    localparam logic [CMD_W-1:0] CMD_GET    = 3'd3;
    localparam logic [CMD_W-1:0] CMD_LOCATE = 3'd4;
    localparam logic [CMD_W-1:0] CMD_PRED   = 3'd5;
    localparam logic [CMD_W-1:0] CMD_SUCC   = 3'd6;

    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
    localparam logic [ST_W-1:0] ST_MISS  = 2'd2;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd3;

    localparam logic [2:0] PTR_HOLD = 3'd0;
    localparam logic [2:0] PTR_INC  = 3'd1;
    localparam logic [2:0] PTR_DEC  = 3'd2;
    localparam logic [2:0] PTR_LEN  = 3'd3;
    localparam logic [2:0] PTR_POS  = 3'd4;
    localparam logic [2:0] PTR_ZERO = 3'd5;

    localparam logic [2:0] RD_PTR     = 3'd0;
    localparam logic [2:0] RD_PTR_M1  = 3'd1;
    localparam logic [2:0] RD_POS_M1  = 3'd2;
    localparam logic [2:0] RD_PREV_M1 = 3'd3;
    localparam logic [2:0] RD_PREV_P1 = 3'd4;

    localparam logic [1:0] WR_NONE = 2'd0;
    localparam logic [1:0] WR_UP   = 2'd1;
    localparam logic [1:0] WR_DN   = 2'd2;
    localparam logic [1:0] WR_VAL  = 2'd3;

    localparam logic [1:0] LEN_HOLD = 2'd0;
    localparam logic [1:0] LEN_CLR  = 2'd1;
    localparam logic [1:0] LEN_INC  = 2'd2;
    localparam logic [1:0] LEN_DEC  = 2'd3;

    typedef struct packed {
        logic            load_in;
        logic [2:0]      ptr_op;
        logic            rd_en;
        logic [2:0]      rd_sel;
        logic [1:0]      wr_op;
        logic [1:0]      len_op;
        logic            cap_value;
        logic            cap_index;
        logic            status_we;
        logic [ST_W-1:0] status_code;
        logic            publish;
    } t_dp_ctl;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             ptr_gt_pos;
        logic             ptr_eq_len;
        logic             pos_gt_len;
        logic             pos_ge_len;
        logic             pos_zero;
        logic             len_full;
        logic             len_zero;
        logic             match;
        logic             raddr_zero;
        logic             raddr_last;
        logic             raddr_eq_pos;
    } t_dp_stat;

endpackage

// ===== hdl/sequential_list_engine.sv =====
// Clear and rejected commands go from decode straight to done; get reads one element.
// Insert shifts the entries from the position upward up by one, then writes the value;
// delete shifts the later entries down. Locate, predecessor and successor scan from entry 0.
// One item in work at a time; the next item is accepted the cycle after publish, and a
// finished item waits while the previous result is still stalled.
// Synchronous active-low reset empties the list; element storage is not cleared.
`timescale 1ns / 1ps
module sequential_list_engine (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_stall,
    input  logic [2:0]             i_command,
    input  logic [6:0]             i_position,
    input  logic signed [31:0]     i_value_in,
    output logic                   o_valid,
    input  logic                   i_stall,
    output logic [1:0]             o_status,
    output logic signed [31:0]     o_value_out,
    output logic [5:0]             o_index_out,
    output logic [6:0]             o_length_out,
    output logic                   o_is_empty
);
    import sle_pkg::*;

    t_dp_ctl  ctl;
    t_dp_stat stat;

    sle_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .i_stat  (stat),
        .o_ctl   (ctl)
    );

    sle_datapath u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (ctl),
        .o_stat       (stat),
        .i_command    (i_command),
        .i_position   (i_position),
        .i_value_in   (i_value_in),
        .o_status     (o_status),
        .o_value_out  (o_value_out),
        .o_index_out  (o_index_out),
        .o_length_out (o_length_out),
        .o_is_empty   (o_is_empty)
    );

endmodule

// ===== hdl/sle_datapath.sv =====
// List engine datapath: element memory, length, pointer, result and output registers.
`timescale 1ns / 1ps
module sle_datapath (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  sle_pkg::t_dp_ctl                i_ctl,
    output sle_pkg::t_dp_stat               o_stat,
    input  logic [sle_pkg::CMD_W-1:0]       i_command,
    input  logic [sle_pkg::POS_W-1:0]       i_position,
    input  logic signed [sle_pkg::ELEM_BITS-1:0] i_value_in,
    output logic [sle_pkg::ST_W-1:0]        o_status,
    output logic signed [sle_pkg::ELEM_BITS-1:0] o_value_out,
    output logic [sle_pkg::ADDR_W-1:0]      o_index_out,
    output logic [sle_pkg::LEN_W-1:0]       o_length_out,
    output logic                            o_is_empty
);
    import sle_pkg::*;

    logic [ELEM_BITS-1:0] r_mem [MAX_ENTRIES];
    logic [ELEM_BITS-1:0] r_rdata;
    logic [ADDR_W-1:0]    r_raddr;
    logic [CMD_W-1:0]     r_cmd;
    logic [POS_W-1:0]     r_pos;
    logic [ELEM_BITS-1:0] r_val;
    logic [LEN_W-1:0]     r_len;
    logic [LEN_W-1:0]     n_len;
    logic [LEN_W-1:0]     r_ptr;
    logic [LEN_W-1:0]     n_ptr;
    logic [ST_W-1:0]      r_status;
    logic [ELEM_BITS-1:0] r_vout;
    logic [ADDR_W-1:0]    r_index;

    logic [ADDR_W-1:0]    rd_addr;
    logic [ADDR_W-1:0]    wr_addr;
    logic [ELEM_BITS-1:0] wr_data;
    logic                 wr_en;
    logic [LEN_W-1:0]     ptr_m1;
    logic [POS_W-1:0]     pos_m1;
    logic [LEN_W-1:0]     raddr_p1;

    assign ptr_m1   = r_ptr - 1'b1;
    assign pos_m1   = r_pos - 1'b1;
    assign raddr_p1 = {1'b0, r_raddr} + 1'b1;

    always_comb begin
        case (i_ctl.rd_sel)
            RD_PTR:     rd_addr = r_ptr[ADDR_W-1:0];
            RD_PTR_M1:  rd_addr = ptr_m1[ADDR_W-1:0];
            RD_POS_M1:  rd_addr = pos_m1[ADDR_W-1:0];
            RD_PREV_M1: rd_addr = r_raddr - 1'b1;
            RD_PREV_P1: rd_addr = r_raddr + 1'b1;
            default:    rd_addr = r_ptr[ADDR_W-1:0];
        endcase
    end

    always_comb begin
        wr_en   = 1'b1;
        wr_data = r_rdata;
        case (i_ctl.wr_op)
            WR_UP:   wr_addr = r_raddr + 1'b1;
            WR_DN:   wr_addr = r_raddr - 1'b1;
            WR_VAL: begin
                wr_addr = r_ptr[ADDR_W-1:0];
                wr_data = r_val;
            end
            default: begin
                wr_addr = r_ptr[ADDR_W-1:0];
                wr_en   = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (i_ctl.rd_en) begin
            r_rdata <= r_mem[rd_addr];
            r_raddr <= rd_addr;
        end
    end

    always_comb begin
        case (i_ctl.ptr_op)
            PTR_INC:  n_ptr = r_ptr + 1'b1;
            PTR_DEC:  n_ptr = r_ptr - 1'b1;
            PTR_LEN:  n_ptr = r_len;
            PTR_POS:  n_ptr = r_pos;
            PTR_ZERO: n_ptr = '0;
            default:  n_ptr = r_ptr;
        endcase
    end

    always_comb begin
        case (i_ctl.len_op)
            LEN_CLR: n_len = '0;
            LEN_INC: n_len = r_len + 1'b1;
            LEN_DEC: n_len = r_len - 1'b1;
            default: n_len = r_len;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= '0;
            r_ptr <= '0;
        end else begin
            r_len <= n_len;
            r_ptr <= n_ptr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load_in) begin
            r_cmd    <= i_command;
            r_pos    <= i_position;
            r_val    <= i_value_in;
            r_status <= ST_OK;
            r_vout   <= '0;
            r_index  <= '0;
        end else begin
            if (i_ctl.status_we) begin
                r_status <= i_ctl.status_code;
            end
            if (i_ctl.cap_value) begin
                r_vout <= r_rdata;
            end
            if (i_ctl.cap_index) begin
                r_index <= r_raddr;
            end
        end
        if (i_ctl.publish) begin
            o_status     <= r_status;
            o_value_out  <= r_vout;
            o_index_out  <= r_index;
            o_length_out <= r_len;
            o_is_empty   <= (r_len == '0);
        end
    end

    assign o_stat.cmd          = r_cmd;
    assign o_stat.ptr_gt_pos   = (r_ptr > r_pos);
    assign o_stat.ptr_eq_len   = (r_ptr == r_len);
    assign o_stat.pos_gt_len   = (r_pos > r_len);
    assign o_stat.pos_ge_len   = (r_pos >= r_len);
    assign o_stat.pos_zero     = (r_pos == '0);
    assign o_stat.len_full     = (r_len == LEN_W'(MAX_ENTRIES));
    assign o_stat.len_zero     = (r_len == '0);
    assign o_stat.match        = (r_rdata == r_val);
    assign o_stat.raddr_zero   = (r_raddr == '0);
    assign o_stat.raddr_last   = (raddr_p1 >= r_len);
    assign o_stat.raddr_eq_pos = ({1'b0, r_raddr} == r_pos);

    a_no_rw_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (wr_en && i_ctl.rd_en) |-> (wr_addr != rd_addr))
        else $error("read and write hit the same entry in one cycle");

    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctl.len_op == LEN_INC) |=> (r_len <= LEN_W'(MAX_ENTRIES)))
        else $error("length grew past capacity");

endmodule

// ===== hdl/sle_ctrl.sv =====
// List engine controller: command sequencing and the item handshakes.
`timescale 1ns / 1ps
module sle_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    output logic               o_valid,
    input  logic               i_stall,
    input  sle_pkg::t_dp_stat  i_stat,
    output sle_pkg::t_dp_ctl   o_ctl
);
    import sle_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECODE = 3'd1;
    localparam logic [2:0] S_UP     = 3'd2;
    localparam logic [2:0] S_DN     = 3'd3;
    localparam logic [2:0] S_SCAN   = 3'd4;
    localparam logic [2:0] S_FETCH  = 3'd5;
    localparam logic [2:0] S_DONE   = 3'd6;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       r_rd_pend;
    logic       n_rd_pend;
    logic       r_out_valid;
    logic       n_out_valid;

    always_comb begin
        n_state     = r_state;
        n_rd_pend   = r_rd_pend;
        n_out_valid = r_out_valid && i_stall;
        o_ctl       = '0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_ctl.load_in = 1'b1;
                    n_state       = S_DECODE;
                end
            end
            S_DECODE: begin
                n_rd_pend = 1'b0;
                n_state   = S_DONE;
                case (i_stat.cmd)
                    CMD_CLEAR: begin
                        o_ctl.len_op = LEN_CLR;
                    end
                    CMD_INSERT: begin
                        if (i_stat.pos_gt_len) begin
                            o_ctl.status_we   = 1'b1;
                            o_ctl.status_code = ST_RANGE;
                        end else if (i_stat.len_full) begin
                            o_ctl.status_we   = 1'b1;
                            o_ctl.status_code = ST_FULL;
                        end else begin
                            o_ctl.ptr_op = PTR_LEN;
                            n_state      = S_UP;
                        end
                    end
                    CMD_DELETE: begin
                        if (i_stat.pos_ge_len) begin
                            o_ctl.status_we   = 1'b1;
                            o_ctl.status_code = ST_RANGE;
                        end else begin
                            o_ctl.ptr_op = PTR_POS;
                            n_state      = S_DN;
                        end
                    end
                    CMD_GET: begin
                        if (i_stat.pos_zero || i_stat.pos_gt_len) begin
                            o_ctl.status_we   = 1'b1;
                            o_ctl.status_code = ST_RANGE;
                        end else begin
                            o_ctl.rd_en  = 1'b1;
                            o_ctl.rd_sel = RD_POS_M1;
                            n_state      = S_FETCH;
                        end
                    end
                    CMD_LOCATE, CMD_PRED, CMD_SUCC: begin
                        o_ctl.ptr_op = PTR_ZERO;
                        n_state      = S_SCAN;
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end
            S_UP: begin
                if (r_rd_pend) begin
                    o_ctl.wr_op = WR_UP;
                end
                if (i_stat.ptr_gt_pos) begin
                    o_ctl.rd_en  = 1'b1;
                    o_ctl.rd_sel = RD_PTR_M1;
                    o_ctl.ptr_op = PTR_DEC;
                    n_rd_pend    = 1'b1;
                end else if (r_rd_pend) begin
                    n_rd_pend = 1'b0;
                end else begin
                    o_ctl.wr_op  = WR_VAL;
                    o_ctl.len_op = LEN_INC;
                    n_state      = S_DONE;
                end
            end
            S_DN: begin
                if (r_rd_pend) begin
                    if (i_stat.raddr_eq_pos) begin
                        o_ctl.cap_value = 1'b1;
                    end else begin
                        o_ctl.wr_op = WR_DN;
                    end
                end
                if (!i_stat.ptr_eq_len) begin
                    o_ctl.rd_en  = 1'b1;
                    o_ctl.rd_sel = RD_PTR;
                    o_ctl.ptr_op = PTR_INC;
                    n_rd_pend    = 1'b1;
                end else if (r_rd_pend) begin
                    n_rd_pend = 1'b0;
                end else begin
                    o_ctl.len_op = LEN_DEC;
                    n_state      = S_DONE;
                end
            end
            S_SCAN: begin
                if (r_rd_pend && i_stat.match) begin
                    o_ctl.cap_index = 1'b1;
                    n_rd_pend       = 1'b0;
                    n_state         = S_DONE;
                    if (i_stat.cmd == CMD_PRED) begin
                        if (i_stat.raddr_zero) begin
                            o_ctl.status_we   = 1'b1;
                            o_ctl.status_code = ST_RANGE;
                        end else begin
                            o_ctl.rd_en  = 1'b1;
                            o_ctl.rd_sel = RD_PREV_M1;
                            n_state      = S_FETCH;
                        end
                    end else if (i_stat.cmd == CMD_SUCC) begin
                        if (i_stat.raddr_last) begin
                            o_ctl.status_we   = 1'b1;
                            o_ctl.status_code = ST_RANGE;
                        end else begin
                            o_ctl.rd_en  = 1'b1;
                            o_ctl.rd_sel = RD_PREV_P1;
                            n_state      = S_FETCH;
                        end
                    end
                end else if (!i_stat.ptr_eq_len) begin
                    o_ctl.rd_en  = 1'b1;
                    o_ctl.rd_sel = RD_PTR;
                    o_ctl.ptr_op = PTR_INC;
                    n_rd_pend    = 1'b1;
                end else begin
                    o_ctl.status_we   = 1'b1;
                    o_ctl.status_code = ST_MISS;
                    n_rd_pend         = 1'b0;
                    n_state           = S_DONE;
                end
            end
            S_FETCH: begin
                o_ctl.cap_value = 1'b1;
                n_state         = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || !i_stall) begin
                    o_ctl.publish = 1'b1;
                    n_out_valid   = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_rd_pend   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_rd_pend   <= n_rd_pend;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_out_valid;

    a_inc_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_ctl.len_op == LEN_INC) |-> !i_stat.len_full)
        else $error("insert completed on a full list");

    a_dec_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_ctl.len_op == LEN_DEC) |-> !i_stat.len_zero)
        else $error("delete completed on an empty list");

    a_publish_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ctl.publish |=> (o_valid && r_state == S_IDLE))
        else $error("published result not presented");

    a_accept_decode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> (r_state == S_DECODE && !o_valid || r_state == S_DECODE))
        else $error("accepted item not decoded");

endmodule

// ===== test/sequential_list_engine_tb.sv =====
// Self-checking testbench for the list engine: directed edge cases, fills and random traffic.
`timescale 1ns / 1ps
module sequential_list_engine_tb;
    import sle_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int DRAIN_CYCLES = 80;

    typedef struct {
        logic [ST_W-1:0]    status;
        logic signed [31:0] value;
        logic [5:0]         index;
        logic [6:0]         length;
        logic               empty;
    } t_list_result;

    logic               i_clk;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic [2:0]         i_command = CMD_CLEAR;
    logic [6:0]         i_position = '0;
    logic signed [31:0] i_value_in = '0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic [1:0]         o_status;
    logic signed [31:0] o_value_out;
    logic [5:0]         o_index_out;
    logic [6:0]         o_length_out;
    logic               o_is_empty;

    logic signed [31:0] shadow_elems [MAX_ENTRIES];
    int                 shadow_len = 0;
    t_list_result       pending_results [$];

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int fail_count = 0;
    int cycle_count = 0;
    int results_checked = 0;
    int cmd_count [8];
    int status_count [4];
    bit growing = 1'b1;

    sequential_list_engine u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_command    (i_command),
        .i_position   (i_position),
        .i_value_in   (i_value_in),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_status     (o_status),
        .o_value_out  (o_value_out),
        .o_index_out  (o_index_out),
        .o_length_out (o_length_out),
        .o_is_empty   (o_is_empty)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles", $time, cycle_count);
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic t_list_result apply_command(logic [2:0] cmd, logic [6:0] pos,
                                                   logic signed [31:0] val);
        t_list_result r;
        int hit;
        int j;
        r.status = ST_OK;
        r.value = '0;
        r.index = '0;
        hit = -1;
        case (cmd)
            CMD_CLEAR: begin
                shadow_len = 0;
            end
            CMD_INSERT: begin
                if (pos > shadow_len) begin
                    r.status = ST_RANGE;
                end else if (shadow_len >= MAX_ENTRIES) begin
                    r.status = ST_FULL;
                end else begin
                    for (j = shadow_len; j > pos; j--) shadow_elems[j] = shadow_elems[j-1];
                    shadow_elems[pos] = val;
                    shadow_len++;
                end
            end
            CMD_DELETE: begin
                if (pos >= shadow_len) begin
                    r.status = ST_RANGE;
                end else begin
                    r.value = shadow_elems[pos];
                    for (j = pos; j + 1 < shadow_len; j++) shadow_elems[j] = shadow_elems[j+1];
                    shadow_len--;
                end
            end
            CMD_GET: begin
                if (pos < 1 || pos > shadow_len) r.status = ST_RANGE;
                else r.value = shadow_elems[pos-1];
            end
            CMD_LOCATE, CMD_PRED, CMD_SUCC: begin
                for (j = 0; j < shadow_len; j++) begin
                    if (hit < 0 && shadow_elems[j] == val) hit = j;
                end
                if (hit < 0) begin
                    r.status = ST_MISS;
                end else begin
                    r.index = hit[5:0];
                    if (cmd == CMD_PRED) begin
                        if (hit == 0) r.status = ST_RANGE;
                        else r.value = shadow_elems[hit-1];
                    end else if (cmd == CMD_SUCC) begin
                        if (hit + 1 >= shadow_len) r.status = ST_RANGE;
                        else r.value = shadow_elems[hit+1];
                    end
                end
            end
            default: ;
        endcase
        r.length = shadow_len[6:0];
        r.empty = (shadow_len == 0);
        cmd_count[cmd]++;
        status_count[r.status]++;
        return r;
    endfunction

    task automatic send_item(logic [2:0] cmd, logic [6:0] pos, logic signed [31:0] val);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_command  <= cmd;
        i_position <= pos;
        i_value_in <= val;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        pending_results.push_back(apply_command(cmd, pos, val));
    endtask

    task automatic check_field(string name, logic signed [63:0] want, logic signed [63:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin : result_check
        t_list_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected item: status %0d value %0d length %0d",
                         $time, o_status, o_value_out, o_length_out);
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                results_checked++;
                check_field("status", want.status, o_status);
                check_field("value_out", want.value, o_value_out);
                check_field("index_out", want.index, o_index_out);
                check_field("length_out", want.length, o_length_out);
                check_field("is_empty", want.empty, o_is_empty);
            end
        end
        i_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    function automatic logic signed [31:0] pick_value();
        int sel;
        sel = $urandom_range(99);
        if (sel < 45) return $signed($urandom_range(15)) - 8;
        if (sel < 50) return (sel & 1) ? 32'sh7fffffff : 32'sh80000000;
        return $urandom();
    endfunction

    function automatic logic signed [31:0] pick_search_value();
        if (shadow_len > 0 && $urandom_range(99) < 70)
            return shadow_elems[$urandom_range(shadow_len - 1)];
        return pick_value();
    endfunction

    function automatic logic [6:0] pick_position(int lo, int hi);
        if (hi < lo || $urandom_range(99) < 10) return 7'($urandom_range(64));
        return 7'($urandom_range(hi, lo));
    endfunction

    task automatic random_item();
        int sel;
        int ins_pct;
        if (shadow_len >= MAX_ENTRIES) growing = 1'b0;
        if (shadow_len == 0) growing = 1'b1;
        if ($urandom_range(99) < 2) growing = ~growing;
        ins_pct = growing ? 42 : 14;
        sel = $urandom_range(99);
        if (sel < 1)
            send_item(CMD_CLEAR, pick_position(0, 64), pick_value());
        else if (sel < 1 + ins_pct)
            send_item(CMD_INSERT, pick_position(0, shadow_len), pick_value());
        else if (sel < 57)
            send_item(CMD_DELETE, pick_position(0, shadow_len - 1), pick_value());
        else if (sel < 71)
            send_item(CMD_GET, pick_position(1, shadow_len), pick_value());
        else if (sel < 81)
            send_item(CMD_LOCATE, pick_position(0, 64), pick_search_value());
        else if (sel < 91)
            send_item(CMD_PRED, pick_position(0, 64), pick_search_value());
        else
            send_item(CMD_SUCC, pick_position(0, 64), pick_search_value());
    endtask

    task automatic test_empty_list();
        send_item(CMD_CLEAR, 7'd0, 32'sd0);
        send_item(CMD_DELETE, 7'd0, 32'sd0);
        send_item(CMD_GET, 7'd0, 32'sd0);
        send_item(CMD_GET, 7'd1, 32'sd0);
        send_item(CMD_LOCATE, 7'd0, 32'sd0);
        send_item(CMD_PRED, 7'd0, 32'sd5);
        send_item(CMD_SUCC, 7'd0, -32'sd1);
        send_item(CMD_INSERT, 7'd1, 32'sd3);
        send_item(CMD_INSERT, 7'd64, 32'sd3);
    endtask

    task automatic test_ends_and_neighbors();
        send_item(CMD_INSERT, 7'd0, 32'sh7fffffff);
        send_item(CMD_INSERT, 7'd1, 32'sh80000000);
        send_item(CMD_INSERT, 7'd1, -32'sd1);
        send_item(CMD_INSERT, 7'd0, 32'sd0);
        send_item(CMD_GET, 7'd1, 32'sd0);
        send_item(CMD_GET, 7'd4, 32'sd0);
        send_item(CMD_GET, 7'd5, 32'sd0);
        send_item(CMD_LOCATE, 7'd0, 32'sh80000000);
        send_item(CMD_LOCATE, 7'd0, 32'sd12345);
        send_item(CMD_PRED, 7'd0, 32'sd0);
        send_item(CMD_SUCC, 7'd0, 32'sh80000000);
        send_item(CMD_PRED, 7'd0, -32'sd1);
        send_item(CMD_SUCC, 7'd0, 32'sd0);
        send_item(CMD_DELETE, 7'd4, 32'sd0);
        send_item(CMD_DELETE, 7'd3, 32'sd0);
        send_item(CMD_DELETE, 7'd0, 32'sd0);
        send_item(CMD_GET, 7'd64, 32'sd0);
    endtask

    task automatic test_fill_to_capacity();
        send_item(CMD_CLEAR, 7'd0, 32'sd0);
        while (shadow_len < MAX_ENTRIES)
            send_item(CMD_INSERT, 7'($urandom_range(shadow_len)), pick_value());
        send_item(CMD_INSERT, 7'd64, pick_value());
        send_item(CMD_INSERT, 7'd0, pick_value());
        send_item(CMD_GET, 7'd64, 32'sd0);
        send_item(CMD_SUCC, 7'd0, shadow_elems[MAX_ENTRIES-1]);
        send_item(CMD_PRED, 7'd0, shadow_elems[MAX_ENTRIES-1]);
        send_item(CMD_DELETE, 7'd63, 32'sd0);
        send_item(CMD_DELETE, 7'd0, 32'sd0);
        send_item(CMD_INSERT, 7'd62, pick_value());
    endtask

    task automatic test_random_traffic(int send_pct, int stall_pct, int num_items);
        send_idle_pct = send_pct;
        recv_stall_pct = stall_pct;
        repeat (num_items) random_item();
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_list();
        test_ends_and_neighbors();
        test_fill_to_capacity();
        test_random_traffic(0, 0, 280);
        test_random_traffic(86, 0, 280);
        test_random_traffic(0, 86, 280);
        test_random_traffic(27, 27, 280);
        test_fill_to_capacity();
        i_valid <= 1'b0;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Commands: %0d clear, %0d insert, %0d delete, %0d get, %0d locate, %s",
                 cmd_count[CMD_CLEAR], cmd_count[CMD_INSERT], cmd_count[CMD_DELETE],
                 cmd_count[CMD_GET], cmd_count[CMD_LOCATE],
                 $sformatf("%0d pred, %0d succ", cmd_count[CMD_PRED], cmd_count[CMD_SUCC]));
        $display("Checked %0d results: %0d ok, %0d out of range, %0d not found, %0d full",
                 results_checked, status_count[ST_OK], status_count[ST_RANGE],
                 status_count[ST_MISS], status_count[ST_FULL]);
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/sle_pkg.sv
hdl/sle_datapath.sv
hdl/sle_ctrl.sv
hdl/sequential_list_engine.sv
test/sequential_list_engine_tb.sv
